// ===== hdl/tcsw_pkg.sv =====
`default_nettype none

package tcsw_pkg;

    // Default geometry of the character store
    localparam int DEF_MAX_COLS = 64;
    localparam int DEF_MAX_ROWS = 32;

    // Fixed field widths
    localparam int ACTION_W  = 2;
    localparam int CHAR_W    = 8;
    localparam int RROW_W    = 5;
    localparam int RCOL_W    = 6;
    localparam int COLNOW_W  = 6;
    localparam int LINENOW_W = 5;
    localparam int ACOLS_W   = 7;
    localparam int AROWS_W   = 6;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 7;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;

    // Register reset values
    localparam logic [ACOLS_W-1:0] RESET_COLS = 7'd51;
    localparam logic [AROWS_W-1:0] RESET_ROWS = 6'd4;

    // Control characters
    localparam logic [CHAR_W-1:0] CH_NUL       = 8'd0;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

    typedef enum logic [ACTION_W-1:0] {
        ACT_WRITE = 2'd0,
        ACT_READ  = 2'd1,
        ACT_CLEAR = 2'd2
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COLS = 1'b0,
        REG_ROWS = 1'b1
    } cfg_reg_t;

    // Result of one step, before the character store data is merged in
    typedef struct packed {
        logic                 use_mem;
        logic [CHAR_W-1:0]    cell_char;
        logic [COLNOW_W-1:0]  column;
        logic [LINENOW_W-1:0] line;
    } tcsw_res_t;

endpackage

`default_nettype wire

// ===== hdl/tcsw_ram.sv =====
`default_nettype none

module tcsw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single port, registered read that holds when not enabled
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hdl/tcsw_core.sv =====
`default_nettype none

module tcsw_core
    import tcsw_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    localparam int ADDR_W  = $clog2(MAX_ROWS * MAX_COLS)
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [ACOLS_W-1:0]   cfg_cols,
    input  wire logic [AROWS_W-1:0]   cfg_rows,
    input  wire logic                 item_valid,
    input  wire logic [ACTION_W-1:0]  item_action,
    input  wire logic [CHAR_W-1:0]    item_char,
    input  wire logic [RROW_W-1:0]    item_row,
    input  wire logic [RCOL_W-1:0]    item_col,
    input  wire logic                 step_en,
    output logic                      fix_busy,
    output tcsw_res_t                 res,
    output logic                      ram_we,
    output logic                      ram_re,
    output logic [ADDR_W-1:0]         ram_addr,
    output logic [CHAR_W-1:0]         ram_wdata
);

    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int CNT_W  = $clog2(MAX_COLS + 1);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int RCNT_W = $clog2(MAX_ROWS + 1);

    typedef struct packed {
        logic [ROW_W-1:0] y;
        logic [ROW_W-1:0] first;
    } pos_t;

    // Cursor and line slot state
    logic [COL_W-1:0] x_reg, x_next;
    logic [ROW_W-1:0] y_reg, y_next;
    logic [ROW_W-1:0] first_reg, first_next;
    logic [CNT_W-1:0] cur_fill_reg, cur_fill_next;
    logic [CNT_W-1:0] fill_reg [MAX_ROWS];

    logic [CNT_W-1:0]  cols_eff;
    logic [RCNT_W-1:0] rows_eff;
    logic [ROW_W-1:0]  last_row;

    logic             fill_we, clr_we, clear_all;
    logic [ROW_W-1:0] fill_wslot, clr_slot, fill_raddr;
    logic [CNT_W-1:0] fill_wval, fill_rdata;
    logic             mem_we, mem_re;

    // Ring slot of a visible row
    function automatic logic [ROW_W-1:0] slot_of(input logic [ROW_W-1:0] first,
                                                  input logic [ROW_W-1:0] row);
        logic [ROW_W:0] s;
        s = {1'b0, first} + {1'b0, row};
        if (s >= (ROW_W+1)'(MAX_ROWS)) begin
            s = s - (ROW_W+1)'(MAX_ROWS);
        end
        return s[ROW_W-1:0];
    endfunction

    // Move to the next line, scrolling at the bottom
    function automatic pos_t next_line(input logic [ROW_W-1:0] y,
                                       input logic [ROW_W-1:0] first,
                                       input logic [RCNT_W-1:0] rows,
                                       input logic [ROW_W-1:0] last);
        pos_t p;
        if ((ROW_W+1)'(y) + (ROW_W+1)'(1) < (ROW_W+1)'(rows)) begin
            p.y     = y + ROW_W'(1);
            p.first = first;
        end else begin
            p.y     = last;
            p.first = slot_of(first, ROW_W'(1));
        end
        return p;
    endfunction

    // Effective geometry from the registers
    always_comb begin
        if (cfg_cols == '0) begin
            cols_eff = CNT_W'(1);
        end else if (32'(cfg_cols) > 32'(MAX_COLS)) begin
            cols_eff = CNT_W'(MAX_COLS);
        end else begin
            cols_eff = CNT_W'(cfg_cols);
        end
        if (cfg_rows == '0) begin
            rows_eff = RCNT_W'(1);
        end else if (32'(cfg_rows) > 32'(MAX_ROWS)) begin
            rows_eff = RCNT_W'(MAX_ROWS);
        end else begin
            rows_eff = RCNT_W'(cfg_rows);
        end
        last_row = ROW_W'(rows_eff - RCNT_W'(1));
    end

    // Cursor below the visible area: pull it to the last line first
    assign fix_busy = item_valid && ((ROW_W+1)'(y_reg) >= (ROW_W+1)'(rows_eff));

    // One line-fill read port: the cursor line while fixing, else the read row
    assign fill_raddr = fix_busy ? slot_of(first_reg, last_row)
                                 : slot_of(first_reg, ROW_W'(item_row));
    assign fill_rdata = fill_reg[fill_raddr];

    // Step logic
    always_comb begin
        logic [COL_W-1:0] xx;
        logic [ROW_W-1:0] slot, rslot;
        logic [CNT_W-1:0] fb, fnew;
        logic [COL_W:0]   xp;
        logic             in_range;
        pos_t             p;

        xx       = '0;
        slot     = '0;
        fb       = '0;
        fnew     = '0;
        xp       = '0;
        in_range = 1'b0;
        p        = '0;

        x_next        = x_reg;
        y_next        = y_reg;
        first_next    = first_reg;
        cur_fill_next = cur_fill_reg;
        fill_we       = 1'b0;
        fill_wslot    = '0;
        fill_wval     = '0;
        clr_we        = 1'b0;
        clr_slot      = '0;
        clear_all     = 1'b0;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        ram_addr      = '0;
        res.use_mem   = 1'b0;
        res.cell_char = CH_NUL;

        rslot = slot_of(first_reg, ROW_W'(item_row));

        unique case (action_t'(item_action))
            ACT_WRITE: begin
                if (item_char == CH_BACKSPACE) begin
                    if (x_reg != '0) begin
                        x_next = x_reg - COL_W'(1);
                    end
                end else if (item_char == CH_RETURN) begin
                    x_next = '0;
                end else if (item_char == CH_NEWLINE) begin
                    p             = next_line(y_reg, first_reg, rows_eff, last_row);
                    x_next        = '0;
                    y_next        = p.y;
                    first_next    = p.first;
                    clr_we        = 1'b1;
                    clr_slot      = slot_of(p.first, p.y);
                    cur_fill_next = '0;
                end else if (item_char != CH_NUL) begin
                    xx = x_reg;
                    fb = cur_fill_reg;
                    p.y     = y_reg;
                    p.first = first_reg;
                    // wrap first when the column count was reduced
                    if ((COL_W+1)'(x_reg) >= (COL_W+1)'(cols_eff)) begin
                        p  = next_line(y_reg, first_reg, rows_eff, last_row);
                        xx = '0;
                        fb = '0;
                    end
                    slot     = slot_of(p.first, p.y);
                    mem_we   = 1'b1;
                    ram_addr = ADDR_W'(ADDR_W'(slot) * ADDR_W'(MAX_COLS) + ADDR_W'(xx));
                    xp       = (COL_W+1)'(xx) + (COL_W+1)'(1);
                    fnew     = ((COL_W+1)'(fb) < xp) ? CNT_W'(xp) : fb;
                    fill_we       = 1'b1;
                    fill_wslot    = slot;
                    fill_wval     = fnew;
                    cur_fill_next = fnew;
                    y_next        = p.y;
                    first_next    = p.first;
                    if (xp >= (COL_W+1)'(cols_eff)) begin
                        p             = next_line(p.y, p.first, rows_eff, last_row);
                        x_next        = '0;
                        y_next        = p.y;
                        first_next    = p.first;
                        clr_we        = 1'b1;
                        clr_slot      = slot_of(p.first, p.y);
                        cur_fill_next = '0;
                    end else begin
                        x_next = COL_W'(xp);
                    end
                end
            end
            ACT_READ: begin
                in_range = (32'(item_row) < 32'(rows_eff)) &&
                           (32'(item_col) < 32'(cols_eff)) &&
                           (32'(item_row) <= 32'(y_reg));
                if (in_range && (32'(item_col) < 32'(fill_rdata))) begin
                    res.use_mem = 1'b1;
                    mem_re      = 1'b1;
                    ram_addr    = ADDR_W'(ADDR_W'(rslot) * ADDR_W'(MAX_COLS) +
                                          ADDR_W'(COL_W'(item_col)));
                end else begin
                    res.cell_char = CH_SPACE;
                end
            end
            ACT_CLEAR: begin
                x_next        = '0;
                y_next        = '0;
                first_next    = '0;
                cur_fill_next = '0;
                clear_all     = 1'b1;
            end
            default: begin
            end
        endcase

        res.column = COLNOW_W'(x_next);
        res.line   = LINENOW_W'(y_next);
    end

    assign ram_we    = step_en && mem_we;
    assign ram_re    = step_en && mem_re;
    assign ram_wdata = item_char;

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg        <= '0;
            y_reg        <= '0;
            first_reg    <= '0;
            cur_fill_reg <= '0;
            for (int i = 0; i < MAX_ROWS; i++) begin
                fill_reg[i] <= '0;
            end
        end else if (fix_busy) begin
            x_reg        <= '0;
            y_reg        <= last_row;
            cur_fill_reg <= fill_rdata;
        end else if (step_en) begin
            x_reg        <= x_next;
            y_reg        <= y_next;
            first_reg    <= first_next;
            cur_fill_reg <= cur_fill_next;
            if (clear_all) begin
                for (int i = 0; i < MAX_ROWS; i++) begin
                    fill_reg[i] <= '0;
                end
            end else begin
                if (fill_we) begin
                    fill_reg[fill_wslot] <= fill_wval;
                end
                // new line starts blank; wins over the fill write
                if (clr_we) begin
                    fill_reg[clr_slot] <= '0;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/text_console_scroll_writer_top.sv =====
// Character text terminal with a scrolling screen of line slots.
// Input stream (s_*): one transfer per action. s_tuser carries the action
// (write character, read visible cell, clear screen); s_tdata carries the
// character byte and the row and column of a read.
// Result stream (m_*): exactly one transfer per input transfer, in order,
// with the cell read (space when unfilled or out of range, zero for other
// actions) and the cursor column and line after the action.
// Configuration: cfg_valid/cfg_index/cfg_data write the column count
// (index 0) and the row count (index 1); cfg_ready is always high.
// A result passes through the input register and then the output register,
// which drives m_tvalid. The block takes one transfer per cycle while
// m_tready is high and no cursor fix is pending; the character store is a
// single port RAM with registered read, written by characters and read by
// cell reads. After the row count has been lowered below the cursor line,
// the next item waits while the cursor is moved onto the last visible line.
// Reset clears the cursor, the scroll position and all line fill counts;
// the registers return to 51 columns and 4 rows.
// When the receiver stalls, the result holds in the output register and
// one more item is held in the input register before s_tready drops.
`default_nettype none

module text_console_scroll_writer_top
    import tcsw_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // input stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,  // char_code[7:0], read_row[12:8], read_col[18:13]
    input  wire logic [ACTION_W-1:0]   s_tuser,  // action[1:0]
    // result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,  // cell_char[7:0], column_now[13:8], line_now[18:14]
    // configuration writes
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int ADDR_W = $clog2(MAX_ROWS * MAX_COLS);

    // Configuration registers
    logic [ACOLS_W-1:0] cols_reg;
    logic [AROWS_W-1:0] rows_reg;

    // Input stage
    logic                a_valid_reg, a_valid_next;
    logic [ACTION_W-1:0] a_action_reg, a_action_next;
    logic [CHAR_W-1:0]   a_char_reg, a_char_next;
    logic [RROW_W-1:0]   a_row_reg, a_row_next;
    logic [RCOL_W-1:0]   a_col_reg, a_col_next;

    // Output stage
    logic      b_valid_reg, b_valid_next;
    tcsw_res_t b_res_reg, b_res_next;

    logic              fix_busy, advance, s_xfer;
    tcsw_res_t         step_res;
    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_addr;
    logic [CHAR_W-1:0] ram_wdata, ram_rdata;
    logic [CHAR_W-1:0] cell_out;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_reg <= RESET_COLS;
            rows_reg <= RESET_ROWS;
        end else if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_COLS: cols_reg <= cfg_data;
                REG_ROWS: rows_reg <= AROWS_W'(cfg_data);
                default: begin
                end
            endcase
        end
    end

    // Handshake: item moves from the input stage into the output stage
    assign advance  = a_valid_reg && !fix_busy && (!b_valid_reg || m_tready);
    assign s_tready = !a_valid_reg || advance;
    assign s_xfer   = s_tvalid && s_tready;

    always_comb begin
        a_valid_next  = a_valid_reg;
        a_action_next = a_action_reg;
        a_char_next   = a_char_reg;
        a_row_next    = a_row_reg;
        a_col_next    = a_col_reg;
        if (s_xfer) begin
            a_valid_next  = 1'b1;
            a_action_next = s_tuser;
            a_char_next   = s_tdata[7:0];
            a_row_next    = s_tdata[12:8];
            a_col_next    = s_tdata[18:13];
        end else if (advance) begin
            a_valid_next  = 1'b0;
        end

        b_valid_next = b_valid_reg;
        b_res_next   = b_res_reg;
        if (advance) begin
            b_valid_next = 1'b1;
            b_res_next   = step_res;
        end else if (m_tready) begin
            b_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_action_reg <= a_action_next;
        a_char_reg   <= a_char_next;
        a_row_reg    <= a_row_next;
        a_col_reg    <= a_col_next;
        b_res_reg    <= b_res_next;
    end

    tcsw_core #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_cols    (cols_reg),
        .cfg_rows    (rows_reg),
        .item_valid  (a_valid_reg),
        .item_action (a_action_reg),
        .item_char   (a_char_reg),
        .item_row    (a_row_reg),
        .item_col    (a_col_reg),
        .step_en     (advance),
        .fix_busy    (fix_busy),
        .res         (step_res),
        .ram_we      (ram_we),
        .ram_re      (ram_re),
        .ram_addr    (ram_addr),
        .ram_wdata   (ram_wdata)
    );

    tcsw_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (MAX_ROWS * MAX_COLS)
    ) u_char_store (
        .aclk  (aclk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Merge the stored byte for reads that hit a filled cell
    assign cell_out = b_res_reg.use_mem ? ram_rdata : b_res_reg.cell_char;

    assign m_tvalid = b_valid_reg;
    assign m_tdata  = {5'b0, b_res_reg.line, b_res_reg.column, cell_out};

endmodule

`default_nettype wire
